// File: src/bspt_pkg.sv
package bspt_pkg;

	localparam int ENTRIES_DEF = 256;
	localparam int QDEPTH = 2;

	localparam logic OP_LEARN = 1'b0;
	localparam logic OP_OBSERVE = 1'b1;
	localparam logic KIND_LEARN = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_RSSI_REF = 2'd1;
	localparam logic [1:0] REG_HIGH_CONF = 2'd2;

	localparam logic [7:0] ALPHA_RST = 8'd64;
	localparam logic [7:0] RSSI_REF_RST = 8'hBA;
	localparam logic [7:0] HIGH_CONF_RST = 8'd3;

	localparam logic [9:0] CONF_NEW = 10'd100;
	localparam logic [9:0] CONF_STEP = 10'd10;
	localparam logic [9:0] CONF_SAT_THR = 10'd990;
	localparam logic [9:0] CONF_MAX = 10'd1000;
	localparam logic [15:0] SAMPLES_MAX = 16'hFFFF;
	localparam logic [3:0] SF_MAX = 4'd10;
	localparam logic [16:0] FACTOR_FULL = 17'd65536;
	// ceil(2^32 / 10000): weight divisor done as multiply plus one correction
	localparam logic [18:0] RECIP_W = 19'd429497;
	localparam logic [13:0] W_DIVISOR = 14'd10000;
	localparam logic [7:0] MATCH_MAX = 8'd255;

	localparam logic [6:0] PCT_HIGH = 7'd70;
	localparam logic [6:0] PCT_MID = 7'd50;
	localparam logic [6:0] PCT_LOW = 7'd30;
	localparam logic [9:0] ACC_HIGH = 10'd80;
	localparam logic [9:0] ACC_MID = 10'd200;
	localparam logic [9:0] ACC_LOW = 10'd500;
	localparam logic [7:0] MATCH_MID = 8'd2;

	typedef struct packed {
		logic [7:0] ema_alpha;
		logic signed [7:0] rssi_ref_dbm;
		logic [7:0] high_conf_matches;
	} cfg_t;

	typedef struct packed {
		logic opcode;
		logic [47:0] bssid;
		logic signed [31:0] lat_in;
		logic signed [31:0] lon_in;
		logic [7:0] origin_tag;
		logic [31:0] now_sec;
		logic signed [7:0] rssi_dbm;
		logic last_obs;
	} req_t;

	typedef struct packed {
		req_t req;
		logic [16:0] factor;
	} qitem_t;

	typedef struct packed {
		logic [47:0] key;
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic [9:0] conf;
		logic [15:0] samples;
		logic [31:0] seen;
		logic [7:0] tag;
	} entry_t;

	typedef struct packed {
		logic result_kind;
		logic ok;
		logic signed [31:0] lat_out;
		logic signed [31:0] lon_out;
		logic [6:0] confidence_pct;
		logic [9:0] radius_m;
		logic [7:0] used_count;
		logic [31:0] estimate_time;
	} res_t;

	typedef enum logic [3:0] {
		BK_IDLE, BK_SCAN, BK_LEARN_MUL, BK_LEARN_WR, BK_INSERT,
		BK_W1, BK_W2, BK_W3, BK_W4, BK_ACC_MUL, BK_ACC_ADD,
		BK_CLOSE, BK_DIV, BK_DIV_FIN, BK_RESULT
	} back_state_t;

	// round(65536 * 2^(-r/10))
	function automatic logic [16:0] pow_rom(input logic [3:0] r);
		logic [16:0] v;
		case (r)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd61147;
			4'd2: v = 17'd57052;
			4'd3: v = 17'd53232;
			4'd4: v = 17'd49667;
			4'd5: v = 17'd46341;
			4'd6: v = 17'd43238;
			4'd7: v = 17'd40342;
			4'd8: v = 17'd37641;
			4'd9: v = 17'd35120;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// File: src/bspt_front.sv
module bspt_front import bspt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input req_t in_req,
	output logic q_valid,
	output qitem_t q_item,
	input logic q_pop
);

	qitem_t fifo_q [QDEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic signed [8:0] d;
	logic [7:0] k;
	logic [15:0] k205;
	logic [4:0] kq;
	logic [3:0] kr;
	logic [16:0] factor;

	// Signal-level factor 2^(-k/10) in Q1.16; k div 10 via k*205 >> 11, exact for k < 1029.
	always_comb begin
		d = 9'(in_req.rssi_dbm) - 9'(cfg.rssi_ref_dbm);
		k = 8'(-d);
		k205 = 16'(k) * 16'd205;
		kq = k205[15:11];
		kr = 4'(k - 8'(kq) * 8'd10);
		if (!d[8])
			factor = FACTOR_FULL;
		else
			factor = pow_rom(kr) >> kq;
	end

	assign in_ready = (cnt_q != 2'(QDEPTH));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{req: in_req, factor: factor};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop && q_valid)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

// File: src/bspt_back.sv
module bspt_back import bspt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic q_valid,
	input qitem_t q_item,
	output logic q_pop,
	output logic res_valid,
	output res_t res,
	input logic res_ready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	back_state_t state_q, state_d;
	entry_t mem_q [ENTRIES];
	entry_t rd_data_s1, wdata;
	logic mem_we;
	logic [IDX_W-1:0] waddr;

	qitem_t cur_q;
	logic [CNT_W-1:0] count_q, scan_q;
	logic rvalid_s1;
	logic [IDX_W-1:0] ridx_s1, hit_idx_q, vict_idx_q;
	entry_t hit_ent_q;
	logic [32:0] vict_sum_q, cand_sum;
	logic scan_hit, scan_end, tbl_full;

	logic signed [40:0] pa_lat_q, pb_lat_q, pa_lon_q, pb_lon_q;
	logic signed [41:0] ema_lat, ema_lon;
	logic [26:0] p1_q;
	logic [29:0] p2_q;
	logic [48:0] p3_q;
	logic [16:0] qe, w_q;
	logic [30:0] qe_chk;
	logic [3:0] sf;
	logic signed [49:0] ml_lat_q, ml_lon_q;

	logic signed [63:0] acc_lat_q, acc_lon_q;
	logic [31:0] acc_w_q;
	logic [7:0] match_q;

	logic [63:0] num_lat_q, num_lon_q;
	logic [31:0] rem_lat_q, rem_lon_q;
	logic neg_lat_q, neg_lon_q;
	logic [5:0] div_cnt_q;
	logic [32:0] sh_lat, sh_lon;
	logic ge_lat, ge_lon;
	res_t res_q;
	res_t res_fin;
	res_t res_empty, res_learn;

	assign tbl_full = (count_q == CNT_W'(ENTRIES));
	assign cand_sum = 33'(rd_data_s1.seen) + 33'(rd_data_s1.samples);
	assign scan_hit = rvalid_s1 && (rd_data_s1.key == cur_q.req.bssid);
	assign scan_end = (scan_q == count_q) && !rvalid_s1;
	assign sf = (hit_ent_q.samples < 16'(SF_MAX)) ? hit_ent_q.samples[3:0] : SF_MAX;
	assign qe = p3_q[48:32];
	assign qe_chk = 31'(qe) * 31'(W_DIVISOR);
	assign ema_lat = 42'(pa_lat_q) + 42'(pb_lat_q);
	assign ema_lon = 42'(pa_lon_q) + 42'(pb_lon_q);
	assign sh_lat = {rem_lat_q, num_lat_q[63]};
	assign sh_lon = {rem_lon_q, num_lon_q[63]};
	assign ge_lat = (sh_lat >= {1'b0, acc_w_q});
	assign ge_lon = (sh_lon >= {1'b0, acc_w_q});

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[waddr] <= wdata;
		rd_data_s1 <= mem_q[scan_q[IDX_W-1:0]];
	end

	// Final lookup result once both quotients are in num_*_q.
	always_comb begin
		res_fin = '0;
		res_fin.result_kind = KIND_LOOKUP;
		res_fin.ok = 1'b1;
		res_fin.lat_out = neg_lat_q ? -num_lat_q[31:0] : num_lat_q[31:0];
		res_fin.lon_out = neg_lon_q ? -num_lon_q[31:0] : num_lon_q[31:0];
		res_fin.used_count = match_q;
		res_fin.estimate_time = cur_q.req.now_sec;
		if (match_q >= cfg.high_conf_matches) begin
			res_fin.confidence_pct = PCT_HIGH;
			res_fin.radius_m = ACC_HIGH;
		end else if (match_q == MATCH_MID) begin
			res_fin.confidence_pct = PCT_MID;
			res_fin.radius_m = ACC_MID;
		end else begin
			res_fin.confidence_pct = PCT_LOW;
			res_fin.radius_m = ACC_LOW;
		end
	end

	// Lookup closed without a usable match, and a finished learn.
	always_comb begin
		res_empty = '0;
		res_empty.result_kind = KIND_LOOKUP;
		res_empty.estimate_time = cur_q.req.now_sec;
		res_learn = '0;
		res_learn.result_kind = KIND_LEARN;
		res_learn.ok = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		mem_we = 1'b0;
		waddr = hit_idx_q;
		wdata = hit_ent_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_hit) begin
					if (cur_q.req.opcode == OP_LEARN)
						state_d = BK_LEARN_MUL;
					else if (match_q != MATCH_MAX)
						state_d = BK_W1;
					else
						state_d = BK_CLOSE;
				end else if (scan_end) begin
					state_d = (cur_q.req.opcode == OP_LEARN) ? BK_INSERT : BK_CLOSE;
				end
			end
			BK_LEARN_MUL: state_d = BK_LEARN_WR;
			BK_LEARN_WR: begin
				mem_we = 1'b1;
				wdata.lat = ema_lat[39:8];
				wdata.lon = ema_lon[39:8];
				wdata.seen = cur_q.req.now_sec;
				if (hit_ent_q.samples != SAMPLES_MAX)
					wdata.samples = hit_ent_q.samples + 16'd1;
				wdata.conf = (hit_ent_q.conf < CONF_SAT_THR) ?
					hit_ent_q.conf + CONF_STEP : CONF_MAX;
				state_d = BK_RESULT;
			end
			BK_INSERT: begin
				mem_we = 1'b1;
				waddr = tbl_full ? vict_idx_q : count_q[IDX_W-1:0];
				wdata = '{key: cur_q.req.bssid, lat: cur_q.req.lat_in,
					lon: cur_q.req.lon_in, conf: CONF_NEW, samples: 16'd1,
					seen: cur_q.req.now_sec, tag: cur_q.req.origin_tag};
				state_d = BK_RESULT;
			end
			BK_W1: state_d = BK_W2;
			BK_W2: state_d = BK_W3;
			BK_W3: state_d = BK_W4;
			BK_W4: state_d = BK_ACC_MUL;
			BK_ACC_MUL: state_d = (w_q != 17'd0) ? BK_ACC_ADD : BK_CLOSE;
			BK_ACC_ADD: state_d = BK_CLOSE;
			BK_CLOSE: begin
				if (!cur_q.req.last_obs)
					state_d = BK_IDLE;
				else if ((match_q != 8'd0) && (acc_w_q != 32'd0))
					state_d = BK_DIV;
				else
					state_d = BK_RESULT;
			end
			BK_DIV: if (div_cnt_q == 6'd63) state_d = BK_DIV_FIN;
			BK_DIV_FIN: state_d = BK_RESULT;
			BK_RESULT: if (res_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rvalid_s1 <= 1'b0;
			acc_lat_q <= '0;
			acc_lon_q <= '0;
			acc_w_q <= '0;
			match_q <= '0;
		end else begin
			case (state_q)
				BK_SCAN: begin
					rvalid_s1 <= (scan_q != count_q) && !scan_hit;
				end
				BK_INSERT: begin
					if (!tbl_full)
						count_q <= count_q + CNT_W'(1);
				end
				BK_ACC_ADD: begin
					acc_lat_q <= acc_lat_q + 64'(ml_lat_q);
					acc_lon_q <= acc_lon_q + 64'(ml_lon_q);
					acc_w_q <= acc_w_q + 32'(w_q);
					match_q <= match_q + 8'd1;
				end
				BK_CLOSE: begin
					if (cur_q.req.last_obs && !((match_q != 8'd0) && (acc_w_q != 32'd0))) begin
						acc_lat_q <= '0;
						acc_lon_q <= '0;
						acc_w_q <= '0;
						match_q <= '0;
					end
				end
				BK_DIV_FIN: begin
					acc_lat_q <= '0;
					acc_lon_q <= '0;
					acc_w_q <= '0;
					match_q <= '0;
				end
				default: rvalid_s1 <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				cur_q <= q_item;
				scan_q <= '0;
				vict_sum_q <= '1;
				vict_idx_q <= '0;
			end
			BK_SCAN: begin
				if (scan_q != count_q)
					scan_q <= scan_q + CNT_W'(1);
				ridx_s1 <= scan_q[IDX_W-1:0];
				if (scan_hit) begin
					hit_idx_q <= ridx_s1;
					hit_ent_q <= rd_data_s1;
				end
				if (rvalid_s1 && (cand_sum < vict_sum_q)) begin
					vict_sum_q <= cand_sum;
					vict_idx_q <= ridx_s1;
				end
			end
			BK_LEARN_MUL: begin
				pa_lat_q <= $signed({1'b0, cfg.ema_alpha}) * cur_q.req.lat_in;
				pb_lat_q <= $signed(10'd256 - 10'(cfg.ema_alpha)) * hit_ent_q.lat;
				pa_lon_q <= $signed({1'b0, cfg.ema_alpha}) * cur_q.req.lon_in;
				pb_lon_q <= $signed(10'd256 - 10'(cfg.ema_alpha)) * hit_ent_q.lon;
			end
			BK_W1: p1_q <= 27'(cur_q.factor) * 27'(hit_ent_q.conf);
			BK_W2: p2_q <= 30'(p1_q) * 30'(sf);
			BK_W3: p3_q <= 49'(p2_q) * 49'(RECIP_W);
			BK_W4: w_q <= (qe_chk > 31'(p2_q)) ? qe - 17'd1 : qe;
			BK_ACC_MUL: begin
				ml_lat_q <= hit_ent_q.lat * $signed({1'b0, w_q});
				ml_lon_q <= hit_ent_q.lon * $signed({1'b0, w_q});
			end
			BK_CLOSE: begin
				neg_lat_q <= acc_lat_q[63];
				neg_lon_q <= acc_lon_q[63];
				num_lat_q <= acc_lat_q[63] ? -acc_lat_q : acc_lat_q;
				num_lon_q <= acc_lon_q[63] ? -acc_lon_q : acc_lon_q;
				rem_lat_q <= '0;
				rem_lon_q <= '0;
				div_cnt_q <= '0;
				res_q <= res_empty;
			end
			BK_DIV: begin
				// One quotient bit per cycle for both coordinates.
				rem_lat_q <= ge_lat ? 32'(sh_lat - {1'b0, acc_w_q}) : sh_lat[31:0];
				rem_lon_q <= ge_lon ? 32'(sh_lon - {1'b0, acc_w_q}) : sh_lon[31:0];
				num_lat_q <= {num_lat_q[62:0], ge_lat};
				num_lon_q <= {num_lon_q[62:0], ge_lon};
				div_cnt_q <= div_cnt_q + 6'd1;
			end
			BK_DIV_FIN: res_q <= res_fin;
			BK_LEARN_WR, BK_INSERT: begin
				res_q <= res_learn;
			end
			default: ;
		endcase
	end

	assign res_valid = (state_q == BK_RESULT);
	assign res = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");
	a_match_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_ACC_ADD |-> match_q != MATCH_MAX)
		else $error("match counter would wrap");
	a_match_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(match_q) |-> $past(state_q) == BK_ACC_ADD ||
		$past(state_q) == BK_CLOSE || $past(state_q) == BK_DIV_FIN)
		else $error("match counter moved outside accumulate or close");
	a_learn_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind == KIND_LEARN |-> res.ok)
		else $error("learn result without ok");

endmodule

// File: src/wifi_bssid_position_table.sv
// Learn: key scan (one entry per cycle), then the EMA multiply and write, or an insert, then the result.
// Observe: the same scan, then weight steps W1 to W4, multiply and accumulate; a closing observe with
// matches adds a bit-serial division. One request is worked on at a time; the table scan sets the pace.
// Up to two further requests queue at the input while one is worked on.
// Reset (arst_n, asynchronous, active low) empties the table and accumulators and loads
// register defaults; table contents need no clearing pass.
module wifi_bssid_position_table import bspt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	// Input stream
	input logic s_tvalid,
	output logic s_tready,
	// bssid[47:0], lat_in[79:48], lon_in[111:80], origin_tag[119:112],
	// now_sec[151:120], rssi_dbm[159:152]
	input logic [159:0] s_tdata,
	// opcode[0]
	input logic s_tuser,
	// last_obs
	input logic s_tlast,
	// Result stream
	output logic m_tvalid,
	input logic m_tready,
	// ok[0], lat_out[32:1], lon_out[64:33], confidence_pct[71:65], radius_m[81:72],
	// used_count[89:82], estimate_time[121:90], zero[127:122]
	output logic [127:0] m_tdata,
	// result_kind[0]
	output logic m_tuser,
	// Configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg_q;
	req_t in_req;
	logic q_valid, q_pop, res_valid, res_ready;
	qitem_t q_item;
	res_t res, out_q;
	logic out_valid_q;

	// The configuration registers sit at byte addresses 0, 4 and 8; a write lands at the
	// access phase. Writes are expected only while the block is idle, so no interlock with
	// requests already queued is needed.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ema_alpha <= ALPHA_RST;
			cfg_q.rssi_ref_dbm <= RSSI_REF_RST;
			cfg_q.high_conf_matches <= HIGH_CONF_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_ALPHA: cfg_q.ema_alpha <= pwdata[7:0];
				REG_RSSI_REF: cfg_q.rssi_ref_dbm <= pwdata[7:0];
				REG_HIGH_CONF: cfg_q.high_conf_matches <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// The signal-level reference reads back sign-extended, as it is held.
	always_comb begin
		case (paddr[3:2])
			REG_ALPHA: prdata = 32'(cfg_q.ema_alpha);
			REG_RSSI_REF: prdata = 32'(cfg_q.rssi_ref_dbm);
			REG_HIGH_CONF: prdata = 32'(cfg_q.high_conf_matches);
			default: prdata = '0;
		endcase
	end

	// Unpack the incoming request. The front part also works out the signal-level
	// weight factor so that the back part need not compute it.
	always_comb begin
		in_req.opcode = s_tuser;
		in_req.bssid = s_tdata[47:0];
		in_req.lat_in = s_tdata[79:48];
		in_req.lon_in = s_tdata[111:80];
		in_req.origin_tag = s_tdata[119:112];
		in_req.now_sec = s_tdata[151:120];
		in_req.rssi_dbm = s_tdata[159:152];
		in_req.last_obs = s_tlast;
	end

	bspt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(in_req),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop)
	);

	// The back part scans the table, updates or inserts entries, builds the weighted
	// centroid and divides it out at the close of a lookup set.
	bspt_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_item(q_item),
		.q_pop(q_pop),
		.res_valid(res_valid),
		.res(res),
		.res_ready(res_ready)
	);

	// Output register: a finished result waits here while the back part starts on the
	// next request.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.result_kind;
	assign m_tdata = {6'd0, out_q.estimate_time, out_q.used_count, out_q.radius_m,
		out_q.confidence_pct, out_q.lon_out, out_q.lat_out, out_q.ok};

endmodule

// File: sim/tb.sv
module tb;
	import bspt_pkg::*;

	// Expected-result record: the fields of one result item.
	typedef struct packed {
		logic kind;
		logic ok;
		logic [31:0] lat;
		logic [31:0] lon;
		logic [6:0] pct;
		logic [9:0] acc;
		logic [7:0] used;
		logic [31:0] etime;
	} estimate_t;

	// The table model and the queue of results it has predicted.
	class position_scoreboard;
		logic [47:0] keys[256];
		longint lats[256];
		longint lons[256];
		int unsigned confs[256];
		int unsigned samps[256];
		int unsigned seens[256];
		int unsigned count;
		longint acc_lat;
		longint acc_lon;
		int unsigned acc_w;
		int unsigned match_cnt;
		int unsigned alpha;
		int ref_dbm;
		int unsigned hi_conf;
		estimate_t pending[$];
		int errors;
		int checked;
		int lookups;

		function void clear();
			count = 0;
			acc_lat = 0;
			acc_lon = 0;
			acc_w = 0;
			match_cnt = 0;
			alpha = 64;
			ref_dbm = -70;
			hi_conf = 3;
		endfunction

		function void set_reg(int idx, logic [7:0] v);
			if (idx == REG_ALPHA)
				alpha = v;
			else if (idx == REG_RSSI_REF)
				ref_dbm = $signed(v);
			else if (idx == REG_HIGH_CONF)
				hi_conf = v;
		endfunction

		function longint blend(longint old, longint nw);
			longint s;
			s = longint'(alpha) * nw + longint'(256 - alpha) * old;
			return s >>> 8;
		endfunction

		// Notes an accepted request and queues the result it causes, if any.
		function void note_request(req_t r);
			int idx;
			int unsigned i;
			int unsigned best;
			longint unsigned bs;
			longint unsigned s;
			int d;
			int unsigned k;
			longint unsigned f;
			longint unsigned w;
			int unsigned sf;
			estimate_t e;
			idx = -1;
			for (int n = 0; n < count; n++)
				if (idx < 0 && keys[n] == r.bssid)
					idx = n;
			e = '0;
			if (r.opcode == OP_LEARN) begin
				if (idx >= 0) begin
					lats[idx] = blend(lats[idx], r.lat_in);
					lons[idx] = blend(lons[idx], r.lon_in);
					seens[idx] = r.now_sec;
					if (samps[idx] < 65535)
						samps[idx]++;
					confs[idx] = (confs[idx] < 990) ? confs[idx] + 10 : 1000;
				end else begin
					if (count < 256) begin
						i = count;
						count++;
					end else begin
						best = 0;
						bs = longint'(seens[0]) + samps[0];
						for (int n = 1; n < 256; n++) begin
							s = longint'(seens[n]) + samps[n];
							if (s < bs) begin
								bs = s;
								best = n;
							end
						end
						i = best;
					end
					keys[i] = r.bssid;
					lats[i] = r.lat_in;
					lons[i] = r.lon_in;
					confs[i] = 100;
					samps[i] = 1;
					seens[i] = r.now_sec;
				end
				e.kind = KIND_LEARN;
				e.ok = 1'b1;
				pending.push_back(e);
				return;
			end
			if (idx >= 0 && match_cnt < 255) begin
				d = int'(r.rssi_dbm) - ref_dbm;
				if (d >= 0)
					f = 65536;
				else begin
					k = -d;
					f = pow_rom(4'(k % 10)) >> (k / 10);
				end
				sf = samps[idx] < 10 ? samps[idx] : 10;
				w = (f * confs[idx] * sf) / 10000;
				if (w > 0) begin
					acc_lat += lats[idx] * longint'(w);
					acc_lon += lons[idx] * longint'(w);
					acc_w += 32'(w);
					match_cnt++;
				end
			end
			if (!r.last_obs)
				return;
			e.kind = KIND_LOOKUP;
			e.etime = r.now_sec;
			if (match_cnt > 0 && acc_w > 0) begin
				e.ok = 1'b1;
				e.lat = 32'(acc_lat / longint'(acc_w));
				e.lon = 32'(acc_lon / longint'(acc_w));
				if (match_cnt >= hi_conf) begin
					e.pct = PCT_HIGH;
					e.acc = ACC_HIGH;
				end else if (match_cnt == 2) begin
					e.pct = PCT_MID;
					e.acc = ACC_MID;
				end else begin
					e.pct = PCT_LOW;
					e.acc = ACC_LOW;
				end
				e.used = 8'(match_cnt);
			end
			acc_lat = 0;
			acc_lon = 0;
			acc_w = 0;
			match_cnt = 0;
			lookups++;
			pending.push_back(e);
		endfunction

		// Compares one delivered result with the oldest prediction.
		function void check_result(logic kind, logic [127:0] d);
			estimate_t e;
			estimate_t a;
			a.kind = kind;
			a.ok = d[0];
			a.lat = d[32:1];
			a.lon = d[64:33];
			a.pct = d[71:65];
			a.acc = d[81:72];
			a.used = d[89:82];
			a.etime = d[121:90];
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result kind=%0d data=%h", kind, d);
				return;
			end
			e = pending.pop_front();
			if (e !== a || d[127:122] !== 6'd0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected %p, got %p", checked, e, a);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [159:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	position_scoreboard table_model;
	// Set while the receiver must hold off; the stall process counts it down.
	int hold_cycles = 0;
	// Known keys, so most requests hit the table.
	logic [47:0] known[$];
	int sent = 0;

	always #6 clk = ~clk;

	wifi_bssid_position_table uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Results are sampled at the rising edge at which the handshake completes.
	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			table_model.check_result(m_tuser, m_tdata);

	// The receiver stalls on a pattern of its own: phases of full speed, of
	// random stalls and of sparse acceptance, plus a long hold-off on request.
	initial begin
		int mode;
		int len;
		mode = 0;
		len = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				m_tready <= 1'b0;
			end else begin
				if (len == 0) begin
					mode = $urandom_range(2);
					len = $urandom_range(5, 200);
				end
				len--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(1) == 1);
					default: m_tready <= ($urandom_range(7) == 0);
				endcase
			end
		end
	end

	// The run is ended here should the block hang.
	initial begin
		#60000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic cfg_write(logic [1:0] idx, logic [7:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		table_model.set_reg(idx, v);
	endtask

	// Offers one request and holds it until the block accepts it.
	task automatic send(req_t r);
		s_tvalid <= 1'b1;
		s_tuser <= r.opcode;
		s_tlast <= r.last_obs;
		s_tdata <= {r.rssi_dbm, r.now_sec, r.origin_tag, r.lon_in, r.lat_in, r.bssid};
		do
			@(posedge clk);
		while (!s_tready);
		table_model.note_request(r);
		sent++;
	endtask

	// The sender works in bursts; the valid is dropped only in a gap.
	task automatic gap();
		int g;
		if ($urandom_range(9) < 7)
			return;
		g = $urandom_range(1, 40);
		s_tvalid <= 1'b0;
		repeat (g)
			@(posedge clk);
	endtask

	function automatic req_t learn(logic [47:0] key, int unsigned t);
		req_t r;
		r.opcode = OP_LEARN;
		r.bssid = key;
		r.lat_in = $urandom;
		r.lon_in = $urandom;
		r.origin_tag = 8'($urandom);
		r.now_sec = t;
		r.rssi_dbm = 8'($urandom);
		r.last_obs = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic req_t observe(logic [47:0] key, logic fin);
		req_t r;
		r = learn(key, $urandom);
		r.opcode = OP_OBSERVE;
		r.rssi_dbm = $urandom_range(1) ? 8'($urandom_range(50) - 100) : 8'($urandom);
		r.last_obs = fin;
		return r;
	endfunction

	function automatic logic [47:0] pick_key();
		if (known.size() > 0 && $urandom_range(9) < 8)
			return known[$urandom_range(known.size() - 1)];
		return 48'({$urandom, $urandom});
	endfunction

	// Waits until every prediction is met, then for one worst-case latency so
	// that an observe without a result has surely finished.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (table_model.pending.size() > 0)
			@(posedge clk);
		repeat (400)
			@(posedge clk);
	endtask

	task automatic random_phase(int n);
		req_t r;
		int set_len;
		logic [47:0] k;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(3) == 0) begin
				k = pick_key();
				r = learn(k, $urandom_range(1) ? $urandom : $urandom_range(100));
				if (known.size() < 400)
					known.push_back(k);
				send(r);
			end else begin
				// A lookup set: several observes, the last one closing it.
				set_len = $urandom_range(1, 6);
				for (int j = 0; j < set_len; j++) begin
					send(observe(pick_key(), j == set_len - 1));
					gap();
				end
				i += set_len - 1;
			end
			gap();
		end
	endtask

	initial begin
		req_t r;
		logic [47:0] k;
		table_model = new();
		table_model.clear();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extremes of the fields, both operations, an EMA hit,
		// a lookup with no match, a lookup with one, two and three matches,
		// very weak and strong signals, and learns in the middle of a set.
		r = learn(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		r.lat_in = 32'sh7FFF_FFFF;
		r.lon_in = 32'sh8000_0000;
		r.origin_tag = 8'hFF;
		send(r);
		r = learn(48'h0, 0);
		r.lat_in = 32'sh8000_0000;
		r.lon_in = 32'sh7FFF_FFFF;
		r.origin_tag = 8'h00;
		send(r);
		r = learn(48'h0, 5);
		send(r);
		r = learn(48'h1234_5678_9ABC, 7);
		send(r);
		known.push_back(48'hFFFF_FFFF_FFFF);
		known.push_back(48'h0);
		known.push_back(48'h1234_5678_9ABC);
		r = observe(48'hDEAD_BEEF_0001, 1'b1);
		send(r);
		r = observe(48'h0, 1'b1);
		r.rssi_dbm = 8'sh7F;
		send(r);
		r = observe(48'h0, 1'b0);
		r.rssi_dbm = 8'sh80;
		send(r);
		r = observe(48'hFFFF_FFFF_FFFF, 1'b0);
		send(r);
		send(learn(48'h1234_5678_9ABC, 9));
		r = observe(48'h1234_5678_9ABC, 1'b1);
		r.now_sec = 32'hFFFF_FFFF;
		send(r);
		r = observe(48'h0, 1'b0);
		send(r);
		r = observe(48'h1234_5678_9ABC, 1'b1);
		send(r);
		drain();

		// Random phases under several register settings, the extremes too.
		cfg_write(REG_ALPHA, 8'd0);
		cfg_write(REG_RSSI_REF, 8'h80);
		cfg_write(REG_HIGH_CONF, 8'd1);
		random_phase(120);
		drain();
		cfg_write(REG_ALPHA, 8'd255);
		cfg_write(REG_RSSI_REF, 8'h7F);
		cfg_write(REG_HIGH_CONF, 8'd255);
		random_phase(120);
		drain();
		cfg_write(REG_ALPHA, 8'd64);
		cfg_write(REG_RSSI_REF, 8'hBA);
		cfg_write(REG_HIGH_CONF, 8'd3);

		// Long hold-off at the receiver while the sender keeps offering, so the
		// input queue fills and the block stalls its input.
		hold_cycles = 3000;
		random_phase(40);
		drain();

		// Fill the table past its size so that replacement is exercised.
		for (int i = 0; i < 300; i++) begin
			k = 48'({$urandom, $urandom});
			known.push_back(k);
			send(learn(k, $urandom_range(2000)));
			gap();
		end
		drain();
		cfg_write(REG_ALPHA, 8'($urandom));
		cfg_write(REG_RSSI_REF, 8'($urandom_range(40) - 90));
		cfg_write(REG_HIGH_CONF, 8'($urandom_range(1, 5)));
		random_phase(220);
		drain();

		$display("Sent %0d requests; %0d results checked, %0d of them lookup estimates.",
			sent, table_model.checked, table_model.lookups);
		$display("Covered table fill and replacement, EMA hits and four register settings.");
		if (table_model.errors == 0 && table_model.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
